// ===== rtl/core/dstq_pkg.sv =====
// Package for the deadline-sorted timer queue: sizes, field widths, codes,
// item structs and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package dstq_pkg;

   // Queue sizing.
   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 32;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths of the channels.
   localparam int HANDLE_W   = 16;
   localparam int DEADLINE_W = 32;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   // Request kinds.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_POLL   = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE_DUE = 2'd3;

   // One request item.
   typedef struct packed {
      logic                  req_type;
      logic [HANDLE_W-1:0]   msg_handle;
      logic [DEADLINE_W-1:0] deadline;
      logic [DEADLINE_W-1:0] now_time;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [HANDLE_W-1:0]   out_handle;
      logic [DEADLINE_W-1:0] out_deadline;
      logic [OCC_W-1:0]      occupancy;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // latch the request and the slot compares
      logic commit;   // update the queue and load the result register
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/deadline_sorted_timer_queue_unit.sv =====
// Top level of the deadline-sorted timer queue: controller plus datapath.
// Depends on dstq_pkg, dstq_ctrl and dstq_datapath.
//
//   Channel  Ports                              Direction  Moves
//   req      req_valid, req_stall, req_item     in         insert or poll item
//   rsp      rsp_valid, rsp_stall, rsp_item     out        one result per item
//
// For each item, the accept cycle registers the request together with a
// parallel compare of every slot deadline; the update state then shifts
// the slot registers and loads the result register.
// Reset empties the queue at once; slot contents are not cleared.
// A stalled result blocks only the update cycle of the following item.
`default_nettype none

module deadline_sorted_timer_queue_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire dstq_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output dstq_pkg::rsp_item_type      rsp_item
);

   dstq_pkg::cmd_type cmd;

   dstq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   dstq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

// ===== rtl/core/dstq_ctrl.sv =====
// Controller of the deadline-sorted timer queue: accept/commit sequencing
// and the result valid flag. Depends on dstq_pkg.
`default_nettype none

module dstq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dstq_pkg::cmd_type     cmd
);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_UPDATE = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // The result register can take a new item when empty or being drained.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_stall   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A commit loads the result; a taken result clears the flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dstq_datapath.sv =====
// Datapath of the deadline-sorted timer queue: slot registers, parallel
// deadline compares, insert/remove shifting and the result register.
// Depends on dstq_pkg.
`default_nettype none

module dstq_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dstq_pkg::cmd_type     cmd,
   input  wire dstq_pkg::req_item_type req_item,
   output dstq_pkg::rsp_item_type     rsp_item
);

   localparam int DEPTH = dstq_pkg::QUEUE_DEPTH;
   localparam int TB    = dstq_pkg::TIME_BITS;
   localparam int CB    = dstq_pkg::COUNT_BITS;

   logic [TB-1:0]                  slot_deadline_ff [DEPTH];
   logic [TB-1:0]                  slot_deadline_in [DEPTH];
   logic [dstq_pkg::HANDLE_W-1:0]  slot_handle_ff   [DEPTH];
   logic [dstq_pkg::HANDLE_W-1:0]  slot_handle_in   [DEPTH];
   logic [CB-1:0]                  count_ff, count_in;

   // Latched request and compare results.
   logic                           op_poll_ff;
   logic [dstq_pkg::HANDLE_W-1:0]  op_handle_ff;
   logic [TB-1:0]                  op_deadline_ff;
   logic [DEPTH-1:0]               le_ff, le_in;
   logic                           due_ff, due_in;

   dstq_pkg::rsp_item_type         rsp_ff, rsp_in;

   logic [DEPTH-1:0]               keep;
   logic                           full;
   logic                           empty;

   // Compare every slot with the new deadline, and the head with the time.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le_in[i] = slot_deadline_ff[i] <= TB'(req_item.deadline);
      end
      due_in = slot_deadline_ff[0] <= TB'(req_item.now_time);
   end

   assign full  = count_ff == CB'(DEPTH);
   assign empty = count_ff == '0;

   // Held slots that stay in place on insert form a prefix of the queue.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keep[i] = le_ff[i] && (CB'(i) < count_ff);
      end
   end

   // Queue update and result on commit.
   always_comb begin
      slot_deadline_in = slot_deadline_ff;
      slot_handle_in   = slot_handle_ff;
      count_in         = count_ff;
      rsp_in           = rsp_ff;
      if (cmd.commit) begin
         rsp_in.out_handle   = '0;
         rsp_in.out_deadline = '0;
         if (!op_poll_ff) begin
            if (full) begin
               rsp_in.status = dstq_pkg::ST_FULL;
            end else begin
               // Insert after all entries not later than the new deadline.
               for (int i = 0; i < DEPTH; i++) begin
                  if (keep[i]) begin
                     slot_deadline_in[i] = slot_deadline_ff[i];
                     slot_handle_in[i]   = slot_handle_ff[i];
                  end else if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
                     slot_deadline_in[i] = op_deadline_ff;
                     slot_handle_in[i]   = op_handle_ff;
                  end else begin
                     slot_deadline_in[i] = slot_deadline_ff[(i == 0) ? 0 : i - 1];
                     slot_handle_in[i]   = slot_handle_ff[(i == 0) ? 0 : i - 1];
                  end
               end
               count_in      = count_ff + CB'(1);
               rsp_in.status = dstq_pkg::ST_INSERTED;
            end
         end else begin
            if (!empty && due_ff) begin
               // Remove the head and move every entry one slot forward.
               rsp_in.out_handle   = slot_handle_ff[0];
               rsp_in.out_deadline = dstq_pkg::DEADLINE_W'(slot_deadline_ff[0]);
               for (int i = 0; i < DEPTH - 1; i++) begin
                  slot_deadline_in[i] = slot_deadline_ff[i + 1];
                  slot_handle_in[i]   = slot_handle_ff[i + 1];
               end
               count_in      = count_ff - CB'(1);
               rsp_in.status = dstq_pkg::ST_EXPIRED;
            end else begin
               rsp_in.status = dstq_pkg::ST_NONE_DUE;
            end
         end
         rsp_in.occupancy = dstq_pkg::OCC_W'(count_in);
      end
   end

   // Entry count is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_deadline_ff <= slot_deadline_in;
      slot_handle_ff   <= slot_handle_in;
      rsp_ff           <= rsp_in;
      if (cmd.capture) begin
         op_poll_ff     <= req_item.req_type == dstq_pkg::REQ_POLL;
         op_handle_ff   <= req_item.msg_handle;
         op_deadline_ff <= TB'(req_item.deadline);
         le_ff          <= le_in;
         due_ff         <= due_in;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

// ===== tb/timer_queue_checker.sv =====
`timescale 1ns / 1ps
// Checker for the deadline-sorted timer queue: keeps its own sorted queue,
// predicts one result per accepted request and compares results as they leave.
// Depends on dstq_pkg.

module timer_queue_checker
   import dstq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_item_type req_item,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_item_type rsp_item,
   output int                open_count,
   output int                fail_count,
   output int                checked_count,
   output int                expired_count,
   output int                dropped_count
);

   localparam int PRINT_CAP = 20;

   // Shadow copy of the queue, head at index 0.
   logic [DEADLINE_W-1:0] shadow_deadline [QUEUE_DEPTH];
   logic [HANDLE_W-1:0]   shadow_handle   [QUEUE_DEPTH];
   int                    shadow_count;

   // Results owed by the block, oldest first.
   rsp_item_type owed_results [$];

   // Prints one line per mismatch (up to a cap) and counts every one.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
   endtask

   // Applies one request to the shadow queue and returns its result.
   function automatic rsp_item_type apply_timer_request(input req_item_type rq);
      rsp_item_type res;
      int           pos;
      res = '0;
      if (rq.req_type == REQ_INSERT) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // Ties go behind every held entry with the same deadline.
            pos = 0;
            while (pos < shadow_count && shadow_deadline[pos] <= rq.deadline)
               pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_deadline[i] = shadow_deadline[i-1];
               shadow_handle[i]   = shadow_handle[i-1];
            end
            shadow_deadline[pos] = rq.deadline;
            shadow_handle[pos]   = rq.msg_handle;
            shadow_count++;
            res.status = ST_INSERTED;
         end
      end else begin
         if (shadow_count == 0 || shadow_deadline[0] > rq.now_time) begin
            res.status = ST_NONE_DUE;
         end else begin
            res.status       = ST_EXPIRED;
            res.out_handle   = shadow_handle[0];
            res.out_deadline = shadow_deadline[0];
            for (int i = 1; i < shadow_count; i++) begin
               shadow_deadline[i-1] = shadow_deadline[i];
               shadow_handle[i-1]   = shadow_handle[i];
            end
            shadow_count--;
         end
      end
      res.occupancy = shadow_count[OCC_W-1:0];
      return res;
   endfunction

   // Compare departing results first, then predict for the accepted request.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         shadow_count = 0;
         owed_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result with nothing outstanding",
                               32'(rsp_item.status), '0);
            end else begin
               want = owed_results.pop_front();
               checked_count++;
               if (rsp_item.status !== want.status)
                  report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
               if (rsp_item.out_handle !== want.out_handle)
                  report_mismatch("out_handle", 32'(rsp_item.out_handle),
                                  32'(want.out_handle));
               if (rsp_item.out_deadline !== want.out_deadline)
                  report_mismatch("out_deadline", 32'(rsp_item.out_deadline),
                                  32'(want.out_deadline));
               if (rsp_item.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_item.occupancy),
                                  32'(want.occupancy));
               if (want.status == ST_EXPIRED) expired_count++;
               if (want.status == ST_FULL) dropped_count++;
            end
         end
         if (req_valid && !req_stall)
            owed_results.push_back(apply_timer_request(req_item));
      end
      open_count <= owed_results.size();
   end

endmodule

// ===== tb/tb_deadline_sorted_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the deadline-sorted timer queue: clock, reset, request
// stimulus, result back-pressure and the verdict. Depends on dstq_pkg,
// deadline_sorted_timer_queue_unit and timer_queue_checker.

module tb_deadline_sorted_timer_queue_unit;
   import dstq_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CALM_ITEMS   = 200;
   localparam int LONG_HOLD    = 150;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   int open_count;
   int fail_count;
   int checked_count;
   int expired_count;
   int dropped_count;

   int   n_inserts    = 0;
   int   n_polls      = 0;
   logic tail_calm    = 1'b0;
   int   holds_asked  = 0;
   int   holds_served = 0;
   int   rx_left      = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   deadline_sorted_timer_queue_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   timer_queue_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .open_count    (open_count),
      .fail_count    (fail_count),
      .checked_count (checked_count),
      .expired_count (expired_count),
      .dropped_count (dropped_count)
   );

   // Result back-pressure: stall bursts alternate with free-running stretches,
   // a requested long hold-off takes priority, and the tail runs without stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_left > 0) begin
         rx_left <= rx_left - 1;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         rsp_stall    <= 1'b1;
         rx_left      <= LONG_HOLD - 1;
      end else if (tail_calm) begin
         rsp_stall <= 1'b0;
      end else if (!rsp_stall && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         rx_left   <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
         rx_left   <= $urandom_range(0, 30);
      end
   end

   // Offers one item, sometimes after an idle burst, and waits until it is taken.
   task automatic send_item(input req_item_type item);
      if (!tail_calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_item  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Unused fields carry random bits so that they are seen to be ignored.
   task automatic insert_timer(input logic [HANDLE_W-1:0] handle,
                               input logic [DEADLINE_W-1:0] due);
      req_item_type item;
      item.req_type   = REQ_INSERT;
      item.msg_handle = handle;
      item.deadline   = due;
      item.now_time   = $urandom();
      n_inserts++;
      send_item(item);
   endtask

   task automatic poll_timer(input logic [DEADLINE_W-1:0] now);
      req_item_type item;
      item.req_type   = REQ_POLL;
      item.msg_handle = 16'($urandom_range(0, 65535));
      item.deadline   = $urandom();
      item.now_time   = now;
      n_polls++;
      send_item(item);
   endtask

   // Stimulus: directed corner cases, then random traffic around a moving time.
   initial begin
      logic [DEADLINE_W-1:0] clock_now;
      logic [DEADLINE_W-1:0] due;
      logic [DEADLINE_W-1:0] now;
      int                    insert_bias;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Polls on an empty queue.
      poll_timer('0);
      poll_timer('1);
      // Extreme handles and deadlines, a tie and a middle value.
      insert_timer(16'h0000, 32'h0000_0000);
      insert_timer(16'hFFFF, 32'hFFFF_FFFF);
      insert_timer(16'h0001, 32'h0000_0000);
      insert_timer(16'h0002, 32'd100);
      // Fill to the last slot in descending order, then overflow.
      for (int k = 0; k < QUEUE_DEPTH - 4; k++)
         insert_timer(16'($urandom_range(0, 65535)), 32'd5000 - 32'd100 * k);
      insert_timer(16'h1234, 32'd50);
      // Ties leave in arrival order; the head is due exactly at its deadline.
      poll_timer('0);
      poll_timer('0);
      poll_timer(32'd99);
      poll_timer(32'd100);

      clock_now   = 32'd1000;
      insert_bias = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Change the insert/poll mix now and then so the queue fills and drains.
         if (n % 150 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_bias = 25;
               1:       insert_bias = 50;
               default: insert_bias = 75;
            endcase
            if ($urandom_range(0, 3) == 0)
               clock_now = $urandom();
         end
         if (n == 400)
            holds_asked <= holds_asked + 1;
         if (n == 900) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (open_count != 0);
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS)
            tail_calm <= 1'b1;

         clock_now = clock_now + $urandom_range(0, 20);
         if ($urandom_range(0, 99) < insert_bias) begin
            case ($urandom_range(0, 9))
               0:       due = $urandom();
               1:       due = clock_now;
               2, 3:    due = clock_now + 32'd16 * $urandom_range(0, 4);
               default: due = clock_now + $urandom_range(0, 300);
            endcase
            insert_timer(16'($urandom_range(0, 65535)), due);
         end else begin
            case ($urandom_range(0, 9))
               0:       now = $urandom();
               1:       now = '1;
               2:       now = clock_now - $urandom_range(0, 100);
               default: now = clock_now;
            endcase
            poll_timer(now);
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (open_count != 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d inserts and %0d polls; %0d results compared.",
               n_inserts, n_polls, checked_count);
      $display("Saw %0d expired entries returned and %0d inserts dropped on a full queue.",
               expired_count, dropped_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding.", open_count);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== deadline_sorted_timer_queue_unit.f =====
rtl/core/dstq_pkg.sv
rtl/core/dstq_ctrl.sv
rtl/core/dstq_datapath.sv
rtl/core/deadline_sorted_timer_queue_unit.sv
tb/timer_queue_checker.sv
tb/tb_deadline_sorted_timer_queue_unit.sv
